/* rtl/anp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anp_pkg: shared types and constants of the ASCII number parser
// Character class codes, the classified beat format and default sizes.
// ----------------------------------------------------------------------------
package anp_pkg;

    localparam int CHAR_BITS          = 8;
    localparam int DIGIT_BITS         = 4;
    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [CHAR_BITS-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CHAR_BITS-1:0] CHAR_PLUS   = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_UP_A   = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_UP_F   = 8'h46;
    localparam logic [CHAR_BITS-1:0] CHAR_UP_X   = 8'h58;
    localparam logic [CHAR_BITS-1:0] CHAR_LO_A   = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_LO_F   = 8'h66;
    localparam logic [CHAR_BITS-1:0] CHAR_LO_X   = 8'h78;

    localparam logic [DIGIT_BITS-1:0] HEX_LETTER_BASE = 4'd10;

    typedef enum logic [3:0] {
        CLS_NUL    = 4'd0,
        CLS_PLUS   = 4'd1,
        CLS_MINUS  = 4'd2,
        CLS_DOLLAR = 4'd3,
        CLS_ZERO   = 4'd4,
        CLS_DEC    = 4'd5,
        CLS_HEXL   = 4'd6,
        CLS_X      = 4'd7,
        CLS_OTHER  = 4'd8
    } anp_class_t;

    typedef struct packed {
        anp_class_t            cls;
        logic [DIGIT_BITS-1:0] dig;
    } anp_item_t;

endpackage

/* rtl/ascii_number_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_number_parser: streaming ASCII to integer converter
// Parse signed decimal or hex strings, one character per beat, NUL-ended.
// ----------------------------------------------------------------------------
// Result path: a NUL beat is written into the beat queue, then the back
//   end moves its value into the result register when no beat waits
//   ahead of it and the result slot is free.
// Throughput: one character beat per cycle while full is low, set by the
//   shift-add accumulator step in the back end.
// Reset: rst_n clears the parse state, the beat queue and the result slot;
//   the block is ready to accept in the first cycle after reset.
// ----------------------------------------------------------------------------
module ascii_number_parser import anp_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // character side
    input  logic                         push,
    output logic                         full,
    input  logic [CHAR_BITS-1:0]         ch,
    // result side
    output logic                         empty,
    input  logic                         pop,
    output logic signed [VALUE_BITS-1:0] value
);

    // Classified beats travel from the front end to the back end through a
    // short queue; a stalled result side backs it up until full is raised.
    logic      queue_wr;
    logic      queue_rd;
    logic      queue_full;
    logic      queue_empty;
    anp_item_t queue_in;
    anp_item_t queue_out;

    // Front end: decode the character into class and digit value.
    anp_front u_front
    (
        .push       (push),
        .ch         (ch),
        .queue_full (queue_full),
        .full       (full),
        .queue_wr   (queue_wr),
        .queue_item (queue_in)
    );

    // Decoupling queue: hold classified beats until the back end takes them.
    anp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (queue_wr),
        .wr_item (queue_in),
        .rd      (queue_rd),
        .rd_item (queue_out),
        .q_full  (queue_full),
        .q_empty (queue_empty)
    );

    // Back end: advance the phase machine and accumulator; a NUL beat
    // waits in the queue until the result slot is free.
    anp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (queue_empty),
        .q_item  (queue_out),
        .q_rd    (queue_rd),
        .pop     (pop),
        .empty   (empty),
        .value   (value)
    );

endmodule

/* rtl/anp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anp_front: character classifier
// Decode each accepted character into a class and digit value for the queue.
// ----------------------------------------------------------------------------
module anp_front import anp_pkg::*;
(
    input  logic                 push,
    input  logic [CHAR_BITS-1:0] ch,
    input  logic                 queue_full,
    output logic                 full,
    output logic                 queue_wr,
    output anp_item_t            queue_item
);

    logic [CHAR_BITS-1:0] dec_off;
    logic [CHAR_BITS-1:0] up_off;
    logic [CHAR_BITS-1:0] lo_off;

    assign dec_off = ch - CHAR_ZERO;
    assign up_off  = ch - CHAR_UP_A;
    assign lo_off  = ch - CHAR_LO_A;

    always_comb
    begin
        queue_item.cls = CLS_OTHER;
        queue_item.dig = '0;
        if (ch == CHAR_NUL)
        begin
            queue_item.cls = CLS_NUL;
        end
        else if (ch == CHAR_PLUS)
        begin
            queue_item.cls = CLS_PLUS;
        end
        else if (ch == CHAR_MINUS)
        begin
            queue_item.cls = CLS_MINUS;
        end
        else if (ch == CHAR_DOLLAR)
        begin
            queue_item.cls = CLS_DOLLAR;
        end
        else if (ch == CHAR_ZERO)
        begin
            queue_item.cls = CLS_ZERO;
        end
        else if (ch > CHAR_ZERO && ch <= CHAR_NINE)
        begin
            queue_item.cls = CLS_DEC;
            queue_item.dig = dec_off[DIGIT_BITS-1:0];
        end
        else if (ch >= CHAR_UP_A && ch <= CHAR_UP_F)
        begin
            queue_item.cls = CLS_HEXL;
            queue_item.dig = up_off[DIGIT_BITS-1:0] + HEX_LETTER_BASE;
        end
        else if (ch >= CHAR_LO_A && ch <= CHAR_LO_F)
        begin
            queue_item.cls = CLS_HEXL;
            queue_item.dig = lo_off[DIGIT_BITS-1:0] + HEX_LETTER_BASE;
        end
        else if (ch == CHAR_UP_X || ch == CHAR_LO_X)
        begin
            queue_item.cls = CLS_X;
        end
    end

    assign full     = queue_full;
    assign queue_wr = push && !queue_full;

endmodule

/* rtl/anp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anp_queue: short beat queue between front and back
// Register-based FIFO with a fill count; head is visible while not empty.
// ----------------------------------------------------------------------------
module anp_queue import anp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  anp_item_t wr_item,
    input  logic      rd,
    output anp_item_t rd_item,
    output logic      q_full,
    output logic      q_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    anp_item_t         slots_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_item = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

/* rtl/anp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anp_back: parse sequencer and accumulator
// Step the phase machine per classified beat and emit the value at NUL.
// ----------------------------------------------------------------------------
module anp_back import anp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  anp_item_t                    q_item,
    output logic                         q_rd,
    input  logic                         pop,
    output logic                         empty,
    output logic signed [VALUE_BITS-1:0] value
);

    typedef enum logic [4:0] {
        PH_START   = 5'b00001,
        PH_SIGNED  = 5'b00010,
        PH_ZERO    = 5'b00100,
        PH_DIGITS  = 5'b01000,
        PH_STOPPED = 5'b10000
    } anp_phase_t;

    anp_phase_t              phase_reg, phase_next;
    logic                    neg_reg, neg_next;
    logic                    hex_reg, hex_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]   out_value_reg, out_value_next;

    logic                    out_free;
    logic                    is_nul;
    logic                    digit_ok;
    logic [VALUE_BITS-1:0]   dig_ext;
    logic [VALUE_BITS-1:0]   acc_dec;
    logic [VALUE_BITS-1:0]   acc_hex;
    logic                    first_pos;

    // Output slot frees up when empty or being drained this cycle.
    assign out_free = !out_valid_reg || pop;
    assign is_nul   = (q_item.cls == CLS_NUL);
    assign q_rd     = !q_empty && (!is_nul || out_free);

    assign dig_ext  = {{(VALUE_BITS - DIGIT_BITS){1'b0}}, q_item.dig};
    assign acc_dec  = (acc_reg << 3) + (acc_reg << 1) + dig_ext;
    assign acc_hex  = (acc_reg << 4) + dig_ext;
    assign digit_ok = (q_item.cls == CLS_ZERO) || (q_item.cls == CLS_DEC)
                   || (hex_reg && q_item.cls == CLS_HEXL);
    assign first_pos = (phase_reg == PH_SIGNED)
                    || (phase_reg == PH_START && q_item.cls != CLS_PLUS
                        && q_item.cls != CLS_MINUS);

    always_comb
    begin
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        hex_next       = hex_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !pop;
        out_value_next = out_value_reg;

        if (q_rd)
        begin
            if (is_nul)
            begin
                out_valid_next = 1'b1;
                out_value_next = neg_reg ? ('0 - acc_reg) : acc_reg;
                phase_next     = PH_START;
                neg_next       = 1'b0;
                hex_next       = 1'b0;
                acc_next       = '0;
            end
            else if (phase_reg == PH_START
                     && (q_item.cls == CLS_PLUS || q_item.cls == CLS_MINUS))
            begin
                neg_next   = (q_item.cls == CLS_MINUS);
                phase_next = PH_SIGNED;
            end
            else if (first_pos && q_item.cls == CLS_DOLLAR)
            begin
                hex_next   = 1'b1;
                phase_next = PH_DIGITS;
            end
            else if (first_pos && q_item.cls == CLS_ZERO)
            begin
                acc_next   = '0;
                phase_next = PH_ZERO;
            end
            else if (phase_reg == PH_ZERO && q_item.cls == CLS_X)
            begin
                hex_next   = 1'b1;
                phase_next = PH_DIGITS;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START, PH_SIGNED, PH_ZERO, PH_DIGITS:
                    begin
                        if (digit_ok)
                        begin
                            acc_next   = hex_reg ? acc_hex : acc_dec;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_STOPPED;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_STOPPED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            neg_reg       <= 1'b0;
            hex_reg       <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            hex_reg       <= hex_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
    end

    assign empty = !out_valid_reg;
    assign value = out_value_reg;

endmodule

/* rtl/anp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anp_checker: port-level checks for the ASCII number parser
// Track NUL beats against popped results and check the result side.
// ----------------------------------------------------------------------------
module anp_checker import anp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         full,
    input  logic [CHAR_BITS-1:0]         ch,
    input  logic                         empty,
    input  logic                         pop,
    input  logic signed [VALUE_BITS-1:0] value
);

    logic       nul_in;
    logic       res_out;
    logic [7:0] pending_reg;

    assign nul_in  = push && !full && (ch == CHAR_NUL);
    assign res_out = pop && !empty;

    // Count strings ended but not yet popped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (nul_in && !res_out)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (res_out && !nul_in)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_empty_in_reset: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown during reset");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pending_reg != 8'd0))
        else $error("result shown without a terminated string");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 8'd0) |=> empty)
        else $error("result appeared one cycle after a NUL beat");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(value)))
        else $error("stalled result changed or vanished");

endmodule

bind ascii_number_parser anp_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_anp_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .ch    (ch),
    .empty (empty),
    .pop   (pop),
    .value (value)
);
